// ===== sv/sseic_pkg.sv =====
// Shared types, field layout and constants of the sorted event insert core.
package sseic_pkg;

    localparam int SSEIC_DEPTH = 64;

    localparam int X_W    = 16;
    localparam int Y_W    = 16;
    localparam int POL_W  = 1;
    localparam int SEC_W  = 32;
    localparam int NSEC_W = 30;
    localparam int OUT_W  = 7;

    localparam int X_LSB    = 0;
    localparam int Y_LSB    = X_LSB + X_W;
    localparam int POL_LSB  = Y_LSB + Y_W;
    localparam int SEC_LSB  = POL_LSB + POL_W;
    localparam int NSEC_LSB = SEC_LSB + SEC_W;
    localparam int IN_BITS  = NSEC_LSB + NSEC_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    localparam int POS_LSB     = 0;
    localparam int CNT_LSB     = POS_LSB + OUT_W;
    localparam int OUT_BITS    = CNT_LSB + OUT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic              pol;
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
    } t_event;

    // What one cell hands to the cell behind it.
    typedef struct packed {
        t_event ev;
        logic   later;
    } t_link;

    // Per-cell control from the top level.
    typedef struct packed {
        logic load;   // an event is being inserted this cycle
        logic valid;  // cell index is below the fill count
        logic tail;   // cell index equals the fill count
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

endpackage

// ===== sv/sseic_cell.sv =====
// One storage cell of the sorted event chain.
module sseic_cell import sseic_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_event    i_new,
    input  t_link     i_prev,
    output t_link     o_link
);

    t_event r_ev;
    logic   w_later;

    // Strictly later: seconds first, then nanoseconds.
    assign w_later = i_ctl.valid &&
                     ((r_ev.sec > i_new.sec) ||
                      ((r_ev.sec == i_new.sec) && (r_ev.nsec > i_new.nsec)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (i_ctl.tail || w_later)) begin
            r_ev <= i_prev.later ? i_prev.ev : i_new;
        end
    end

    assign o_link.ev    = r_ev;
    assign o_link.later = w_later;

endmodule

// ===== sv/sseic_pos_search.sv =====
// Binary search for the insert position over captured later-than flags.
module sseic_pos_search import sseic_pkg::*; #(
    parameter int BUFFER_DEPTH = SSEIC_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(BUFFER_DEPTH+1)-1:0] i_hi,
    input  logic [BUFFER_DEPTH-1:0]           i_later,
    output logic                              o_done,
    output logic [$clog2(BUFFER_DEPTH+1)-1:0] o_pos
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int AW = $clog2(BUFFER_DEPTH);

    logic [BUFFER_DEPTH-1:0] r_later;
    logic [CW-1:0]           r_lo, r_hi, n_lo, n_hi;
    logic [CW:0]             w_sum;
    logic [CW-1:0]           w_mid;

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid = w_sum[CW:1];

    // Later flags form a suffix; find the first set flag in [lo, hi).
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_start) begin
            n_lo = '0;
            n_hi = i_hi;
        end else if (r_lo != r_hi) begin
            if (r_later[w_mid[AW-1:0]]) begin
                n_hi = w_mid;
            end else begin
                n_lo = w_mid + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_later <= i_later;
        end
    end

    assign o_done = (r_lo == r_hi);
    assign o_pos  = r_lo;

endmodule

// ===== sv/stable_sorted_event_insert_core.sv =====
// Top level of the stable timestamp-sorted event insert core.
// Keeps up to BUFFER_DEPTH camera events in a row of cells in ascending time
// order (seconds, then nanoseconds, raw values). A new event goes behind every
// stored event with an equal or earlier time, so equal times keep arrival
// order; every strictly later entry moves one cell back in the same cycle as
// the input beat is taken. Each input beat yields one output beat with the
// insert position and the new fill count; when the buffer is full the event
// is discarded, tuser is set, the position reads zero and the count holds.
// An inserted event is placed by a binary search over the later-than flags
// captured from the cells, one probe per cycle, across the fill count before
// the event; a dropped event searches an empty range. The next input beat is
// taken only once the search is done and its result is loaded, which a
// stalled earlier output beat holds off; it is taken while that result beat
// still waits. Input is held off during reset.
// Stored entries have no reset; the fill count clears on reset.
module stable_sorted_event_insert_core import sseic_pkg::*; #(
    parameter int BUFFER_DEPTH = SSEIC_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pixel_x[15:0], pixel_y[31:16], event_polarity[32], time_seconds[64:33],
    // time_nanoseconds[94:65], zero pad[95]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // insert_position[6:0], entry_count[13:7], zero pad[15:14]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // dropped[0]
    output logic [0:0]             m_axis_tuser
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count;
    logic          r_drop;
    logic          r_out_valid;
    logic [OUT_W-1:0] r_out_pos, r_out_count;
    logic          r_out_drop;

    logic          w_in_acc, w_full, w_load, w_done, w_out_load;
    logic [CW-1:0] w_pos;
    logic [CW+OUT_W-1:0] w_pos_ext, w_cnt_ext;
    t_event        w_new;
    t_link         w_link [BUFFER_DEPTH];
    t_link         w_prev [BUFFER_DEPTH];
    logic [BUFFER_DEPTH-1:0] w_later;

    // Unpack the input beat.
    assign w_new.x    = s_axis_tdata[X_LSB +: X_W];
    assign w_new.y    = s_axis_tdata[Y_LSB +: Y_W];
    assign w_new.pol  = s_axis_tdata[POL_LSB];
    assign w_new.sec  = s_axis_tdata[SEC_LSB +: SEC_W];
    assign w_new.nsec = s_axis_tdata[NSEC_LSB +: NSEC_W];

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_full   = (r_count == CW'(BUFFER_DEPTH));
    assign w_load   = w_in_acc && !w_full;

    // Cell chain: each cell compares against the new event and, when it is later
    // or is the first free cell, takes its front neighbor's entry or the new event.
    for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.load  = w_load;
        assign w_ctl.valid = (CW'(g) < r_count);
        assign w_ctl.tail  = (CW'(g) == r_count);

        if (g == 0) begin : g_head
            assign w_prev[g] = '{ev: '0, later: 1'b0};
        end else begin : g_body
            assign w_prev[g] = w_link[g-1];
        end

        sseic_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_new  (w_new),
            .i_prev (w_prev[g]),
            .o_link (w_link[g])
        );

        assign w_later[g] = w_link[g].later;
    end

    // Position search on the pre-insert flags; a dropped event searches
    // an empty range and ends at zero at once.
    sseic_pos_search #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_acc),
        .i_hi    (w_full ? CW'(0) : r_count),
        .i_later (w_later),
        .o_done  (w_done),
        .o_pos   (w_pos)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs and result load strobe.
    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // Hold off input beats while reset is asserted.
                s_axis_tready = i_rst_n;
            end
            ST_SEARCH: begin
                w_out_load = w_done && (!r_out_valid || m_axis_tready);
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_drop <= w_full;
        end
    end

    // Keep the low bits of position and count on the output fields.
    assign w_pos_ext = {{OUT_W{1'b0}}, w_pos};
    assign w_cnt_ext = {{OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pos   <= w_pos_ext[OUT_W-1:0];
            r_out_count <= w_cnt_ext[OUT_W-1:0];
            r_out_drop  <= r_drop;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, r_out_count, r_out_pos};
    assign m_axis_tuser  = r_out_drop;

endmodule

// ===== sv/sseic_checker.sv =====
// Port-level checker for the sorted event insert core, bound to the top level.
module sseic_checker import sseic_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]             m_axis_tuser
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // A dropped event reports position zero.
    a_drop_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[POS_LSB +: OUT_W] == '0)
        else $error("dropped event with nonzero position");

    // One event at a time: input closes right after a beat is taken.
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an event is in flight");

endmodule

bind stable_sorted_event_insert_core sseic_checker u_sseic_checker (.*);

// ===== tb/tb_stable_sorted_event_insert_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the stable timestamp-sorted event insert core.
module tb_stable_sorted_event_insert_core;
    import sseic_pkg::*;

    localparam int CLK_HALF_NS  = 10;
    localparam int DEPTH        = SSEIC_DEPTH;
    localparam int ITEM_TARGET  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 500_000;

    // One output beat: insert position, fill count after the event, drop flag.
    typedef struct packed {
        logic [OUT_W-1:0] pos;
        logic [OUT_W-1:0] count;
        logic             dropped;
    } t_insert_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // pixel_x, pixel_y, event_polarity, time_seconds, time_nanoseconds, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // insert_position, entry_count, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // dropped
    logic [0:0]             m_axis_tuser;

    // Shadow copy of the sorted buffer, oldest time first.
    t_event         sorted_events [DEPTH];
    int             sorted_count;
    t_insert_result awaited_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int events_sent;
    int inserts_seen;
    int drops_seen;

    stable_sorted_event_insert_core #(
        .BUFFER_DEPTH (DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF_NS i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Insert into the shadow buffer behind every equal or earlier time and
    // return the beat the core must produce.
    function automatic t_insert_result place_event(input t_event ev);
        t_insert_result res;
        int             slot;
        if (sorted_count >= DEPTH) begin
            res.pos     = '0;
            res.count   = OUT_W'(sorted_count);
            res.dropped = 1'b1;
            return res;
        end
        slot = sorted_count;
        while (slot > 0 &&
               {sorted_events[slot-1].sec, sorted_events[slot-1].nsec} > {ev.sec, ev.nsec}) begin
            sorted_events[slot] = sorted_events[slot-1];
            slot--;
        end
        sorted_events[slot] = ev;
        sorted_count++;
        res.pos     = OUT_W'(slot);
        res.count   = OUT_W'(sorted_count);
        res.dropped = 1'b0;
        return res;
    endfunction

    function automatic t_event make_event(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                          input logic pol, input logic [SEC_W-1:0] sec,
                                          input logic [NSEC_W-1:0] nsec);
        t_event ev;
        ev.x    = x;
        ev.y    = y;
        ev.pol  = pol;
        ev.sec  = sec;
        ev.nsec = nsec;
        return ev;
    endfunction

    // Random payload; the timestamp leans toward collisions with stored times,
    // toward the low ends of both time fields and toward either end of seconds.
    function automatic t_event random_event();
        t_event ev;
        ev.x   = X_W'($urandom);
        ev.y   = Y_W'($urandom);
        ev.pol = POL_W'($urandom);
        case ($urandom_range(4))
            0: begin
                if (sorted_count > 0) begin
                    ev.sec  = sorted_events[$urandom_range(sorted_count - 1)].sec;
                    ev.nsec = sorted_events[$urandom_range(sorted_count - 1)].nsec;
                    if ($urandom_range(1)) begin
                        ev.nsec = sorted_events[$urandom_range(sorted_count - 1)].nsec;
                    end
                end else begin
                    ev.sec  = '0;
                    ev.nsec = '0;
                end
            end
            1: begin
                ev.sec  = SEC_W'($urandom_range(3));
                ev.nsec = NSEC_W'($urandom_range(3));
            end
            2: begin
                ev.sec  = SEC_W'($urandom);
                ev.nsec = NSEC_W'($urandom_range(999_999_999));
            end
            3: begin
                ev.sec  = SEC_W'($urandom);
                ev.nsec = NSEC_W'($urandom);
            end
            default: begin
                ev.sec  = $urandom_range(1) ? '1 : '0;
                ev.nsec = NSEC_W'($urandom);
            end
        endcase
        return ev;
    endfunction

    // Present one event and hold it until the core takes the beat. Valid stays
    // high across back-to-back beats; drop it only for a sender gap.
    task automatic send_event(input t_event ev);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, ev.nsec, ev.sec, ev.pol, ev.y, ev.x};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        awaited_results.insert(awaited_results.size(), place_event(ev));
        events_sent++;
    endtask

    // Check each output beat against the oldest awaited result, then pick the
    // ready level for the next edge.
    always @(posedge i_clk) begin : result_check
        t_insert_result got;
        t_insert_result want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got.pos     = m_axis_tdata[POS_LSB +: OUT_W];
            got.count   = m_axis_tdata[CNT_LSB +: OUT_W];
            got.dropped = m_axis_tuser[0];
            if (got.dropped === 1'b1) begin
                drops_seen++;
            end else begin
                inserts_seen++;
            end
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("beat with nothing awaited: pos %0d count %0d drop %b",
                                          got.pos, got.count, got.dropped));
            end else begin
                want = awaited_results.pop_front();
                if (got.pos !== want.pos) begin
                    report_mismatch($sformatf("insert_position %0d, want %0d", got.pos, want.pos));
                end
                if (got.count !== want.count) begin
                    report_mismatch($sformatf("entry_count %0d, want %0d", got.count, want.count));
                end
                if (got.dropped !== want.dropped) begin
                    report_mismatch($sformatf("dropped %b, want %b", got.dropped, want.dropped));
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Field extremes and ordering decided by seconds, by nanoseconds alone, and
    // by raw nanoseconds past one second.
    task automatic test_order_extremes();
        send_event(make_event(16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 30'h0000_0000));
        send_event(make_event(16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 30'h3FFF_FFFF));
        send_event(make_event(16'h8001, 16'h7FFE, 1'b1, 32'hFFFF_FFFF, 30'd999_999_999));
        send_event(make_event(16'h1234, 16'h5678, 1'b0, 32'd1, 30'd0));
        send_event(make_event(16'hA5A5, 16'h5A5A, 1'b1, 32'd0, 30'd1_000_000_000));
        send_event(make_event(16'h00FF, 16'hFF00, 1'b0, 32'h8000_0000, 30'h2000_0000));
        send_event(make_event(16'h0F0F, 16'hF0F0, 1'b1, 32'd2, 30'd999_999_999));
    endtask

    // Equal times must land behind their twins, in arrival order.
    task automatic test_equal_time_stability();
        send_event(make_event(16'd1, 16'd10, 1'b0, 32'd5, 30'd500));
        send_event(make_event(16'd2, 16'd20, 1'b1, 32'd5, 30'd500));
        send_event(make_event(16'd3, 16'd30, 1'b0, 32'd5, 30'd500));
        send_event(make_event(16'd4, 16'd40, 1'b1, 32'd0, 30'd0));
        send_event(make_event(16'd5, 16'd50, 1'b0, 32'd5, 30'd499));
        send_event(make_event(16'd6, 16'd60, 1'b1, 32'd4, 30'h3FFF_FFFF));
        send_event(make_event(16'd7, 16'd70, 1'b0, 32'd5, 30'd500));
        send_event(make_event(16'd8, 16'd80, 1'b1, 32'd5, 30'd501));
        send_event(make_event(16'd9, 16'd90, 1'b0, 32'hFFFF_FFFF, 30'h3FFF_FFFF));
    endtask

    // Fill the remaining slots with random times, many of them colliding.
    task automatic test_fill_to_capacity();
        while (sorted_count < DEPTH) begin
            send_event(random_event());
        end
    endtask

    // With the buffer full every event is turned away and the count holds.
    task automatic test_full_buffer_drops(input int n_events);
        repeat (n_events) begin
            send_event(random_event());
        end
    endtask

    initial begin : stimulus
        int drop_share;
        send_idle_pct = 11;
        recv_idle_pct = 45;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_order_extremes();
        test_equal_time_stability();

        send_idle_pct = 45;
        recv_idle_pct = 11;
        test_fill_to_capacity();

        drop_share    = (ITEM_TARGET - events_sent) / 3;
        send_idle_pct = 11;
        recv_idle_pct = 45;
        test_full_buffer_drops(drop_share);
        send_idle_pct = 45;
        recv_idle_pct = 11;
        test_full_buffer_drops(drop_share);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_buffer_drops(ITEM_TARGET - events_sent);

        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d events into a %0d-entry buffer: %0d placed in time order, %0d dropped.",
                 events_sent, DEPTH, inserts_seen, drops_seen);
        $display("Mismatches: %0d, results never delivered: %0d.",
                 error_count, awaited_results.size());
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("stable_sorted_event_insert_core regression: pass");
        end else begin
            $display("stable_sorted_event_insert_core regression: fail");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * CLK_HALF_NS);
        $display("Timeout with %0d results still awaited.", awaited_results.size());
        $display("stable_sorted_event_insert_core regression: fail");
        $finish;
    end

endmodule
